FILE: rtl/ssa_pkg.sv
// Package for the scaled scatter accumulator: field widths, operation codes,
// controller state type and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package ssa_pkg;

  localparam int unsigned IDX_W   = 12;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned PROD_W  = 2 * VAL_W;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned IN_TDATA_W = 48;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_ACC
  } ssa_state_t;

  typedef struct packed {
    logic clear;   // write zero at the clear counter and advance it
    logic take;    // ready for an input beat
    logic mul;     // register the product
    logic commit;  // write back the entry and load the output register
  } ssa_cmd_t;

  typedef struct packed {
    logic clr_last;  // the clear counter is at the final entry
    logic out_free;  // the output register can take a result this cycle
  } ssa_sts_t;

endpackage

`default_nettype wire

FILE: rtl/ssa_ctrl.sv
// Controller for the scaled scatter accumulator: clear pass after reset, then
// accept, multiply and accumulate steps for one item at a time.
// Depends on ssa_pkg.
`default_nettype none

module ssa_ctrl
  import ssa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  input  wire ssa_sts_t sts,
  output ssa_cmd_t      cmd
);

  ssa_state_t state_r;
  ssa_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_CLEAR: cmd.clear  = 1'b1;
      ST_IDLE:  cmd.take   = 1'b1;
      ST_MUL:   cmd.mul    = 1'b1;
      ST_ACC:   cmd.commit = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/ssa_dp.sv
// Datapath for the scaled scatter accumulator: scale register, accumulator memory,
// multiplier, saturating adder and output register.
// Depends on ssa_pkg; driven by ssa_ctrl.
`default_nettype none

module ssa_dp
  import ssa_pkg::*;
#(
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ssa_cmd_t              cmd,
  output ssa_sts_t                   sts,
  input  wire logic                  cfg_we,
  input  wire logic [VAL_W-1:0]      cfg_wdata,
  input  wire logic                  in_tvalid,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic                  in_tuser,
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [VAL_W-1:0]           out_tdata,
  output logic                       out_tuser,
  output logic                       out_tlast
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic signed [VAL_W-1:0] SAT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] SAT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  logic [VAL_W-1:0] mem [DEPTH];

  logic signed [VAL_W-1:0]  scale_r;
  logic [AW-1:0]            clr_cnt_r;
  logic                     op_r;
  logic [AW-1:0]            addr_r;
  logic                     in_range_r;
  logic signed [VAL_W-1:0]  value_r;
  logic                     last_r;
  logic signed [VAL_W-1:0]  rdata_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     out_valid_r;
  logic [VAL_W-1:0]         out_data_r;
  logic                     out_sat_r;
  logic                     out_last_r;

  logic                     accept;
  logic [31:0]              idx_ext;
  logic [AW-1:0]            in_addr;
  logic                     in_range;
  logic signed [PROD_W-FRAC_W-1:0] prod_q;
  logic signed [PROD_W-FRAC_W:0]   sum;
  logic                     ovf;
  logic signed [VAL_W-1:0]  sum_sat;
  logic [VAL_W-1:0]         res_data;
  logic                     res_sat;
  logic                     wr_en;

  assign accept   = cmd.take & in_tvalid;
  assign idx_ext  = {{(32-IDX_W){1'b0}}, in_tdata[IDX_W-1:0]};
  assign in_addr  = idx_ext[AW-1:0];
  assign in_range = idx_ext < 32'(DEPTH);

  assign sts.clr_last = (clr_cnt_r == LAST_ADDR);
  assign sts.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= VAL_W'(65536);
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear && !sts.clr_last) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_tuser;
      addr_r     <= in_addr;
      in_range_r <= in_range;
      value_r    <= in_tdata[IDX_W +: VAL_W];
      last_r     <= in_tlast;
      rdata_r    <= mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= value_r * scale_r;
    end
  end

  // Dropping the low fraction bits of a two's complement product floors it.
  assign prod_q = prod_r[PROD_W-1:FRAC_W];
  assign sum    = {{(PROD_W-FRAC_W-VAL_W+1){rdata_r[VAL_W-1]}}, rdata_r}
                + {prod_q[PROD_W-FRAC_W-1], prod_q};
  assign ovf    = !((&sum[PROD_W-FRAC_W:VAL_W-1]) || !(|sum[PROD_W-FRAC_W:VAL_W-1]));

  always_comb begin
    if (!ovf) begin
      sum_sat = sum[VAL_W-1:0];
    end else if (sum[PROD_W-FRAC_W]) begin
      sum_sat = SAT_MIN;
    end else begin
      sum_sat = SAT_MAX;
    end
  end

  always_comb begin
    wr_en    = 1'b0;
    res_data = '0;
    res_sat  = 1'b0;
    if (in_range_r) begin
      if (op_r == OP_UPDATE) begin
        wr_en    = 1'b1;
        res_data = sum_sat;
        res_sat  = ovf;
      end else begin
        res_data = rdata_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_cnt_r] <= '0;
    end else if (cmd.commit && wr_en) begin
      mem[addr_r] <= sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= res_data;
      out_sat_r  <= res_sat;
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/scaled_scatter_accumulator_unit.sv
// Scaled scatter accumulator: each update beat adds value * scale (signed Q16.16,
// saturating) into the addressed entry; a read beat returns the entry unchanged.
//
// Channels: in_* carries one item per beat (tuser = operation, tlast = end of
// batch); out_* returns exactly one result per item in order (tuser = saturated,
// tlast = echo of the batch end). cfg_we/cfg_wdata write the scale register,
// which resets to 1.0 and should only be changed while the block is idle.
//
// Timing: one item is in flight at a time. Accepting an input beat also reads
// the entry; the MUL state then registers the 32x32 product, and the ACC state
// writes the saturated sum to the entry and the output register together,
// waiting there while the output register still holds an unaccepted result.
// The next input beat is taken as soon as the previous result sits in the
// output register, so a stalled receiver delays only the write-back step.
//
// Reset: rst_n is synchronous and active low. Afterwards the accumulator is
// zeroed one entry per cycle, all DEPTH entries, with in_tready held low.
// Indices at or beyond DEPTH are not stored and read back as zero.
// Depends on ssa_pkg, ssa_ctrl and ssa_dp.
`default_nettype none

module scaled_scatter_accumulator_unit
  import ssa_pkg::*;
#(
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [VAL_W-1:0]      cfg_wdata,   // scale
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,    // entry_index, value, zero pad
  input  wire logic                  in_tuser,    // operation
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [VAL_W-1:0]           out_tdata,   // entry_value
  output logic                       out_tuser,   // saturated
  output logic                       out_tlast
);

  ssa_cmd_t cmd;
  ssa_sts_t sts;

  ssa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .sts       (sts),
    .cmd       (cmd)
  );

  ssa_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  assign in_tready = cmd.take;

endmodule

`default_nettype wire

FILE: rtl/ssa_checker.sv
// Port-level checks for the scaled scatter accumulator, bound to the top level.
// Depends on ssa_pkg and scaled_scatter_accumulator_unit.
`default_nettype none

module ssa_checker
  import ssa_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [VAL_W-1:0]      out_tdata,
  input wire logic                  out_tuser
);

  // The clear pass follows every reset, so no beat is taken right after it.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input accepted during the clear pass");

  // Only one item is in flight: an accepted beat keeps in_tready low in the next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat accepted while an item is in flight");

  // A saturated result carries one of the two clamp limits.
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 32'h7fff_ffff || out_tdata == 32'h8000_0000)
    else $error("saturated flag without a clamp value");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind scaled_scatter_accumulator_unit ssa_checker u_ssa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for scaled_scatter_accumulator_unit: a scoreboard
// that multiplies each update value by the scale and saturates the sum is checked
// against every result beat. Depends on ssa_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
  import ssa_pkg::*;

  localparam int unsigned ENTRIES    = 1 << IDX_W;
  localparam int unsigned LONG_HOLD  = 300;
  localparam int unsigned CYCLE_CAP  = 1000000;
  localparam int unsigned PHASE_LEN  = 200;

  typedef struct packed {
    logic [VAL_W-1:0] entry_value;
    logic             saturated;
    logic             batch_done;
  } acc_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [VAL_W-1:0] cfg_wdata;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;  // entry_index, value, zero pad
  logic in_tuser;                   // operation
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [VAL_W-1:0] out_tdata;      // entry_value
  logic out_tuser;                  // saturated
  logic out_tlast;

  // Scoreboard state: a copy of the store and of the scale register.
  logic [VAL_W-1:0] acc_store [ENTRIES];
  logic [VAL_W-1:0] scale_q;
  acc_result_t      pending_results[$];

  int  mismatches = 0;
  int  cycle_count = 0;
  bit  no_idle = 1'b0;
  bit  hold_request = 1'b0;

  scaled_scatter_accumulator_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Applies one item to the scoreboard and returns the result it should give.
  function automatic acc_result_t scale_and_accumulate(logic op, logic [IDX_W-1:0] idx,
                                                       logic [VAL_W-1:0] operand,
                                                       logic last);
    acc_result_t res;
    longint prod;
    longint sum;
    res.saturated  = 1'b0;
    res.batch_done = last;
    if (op == OP_UPDATE) begin
      // The arithmetic shift of a signed product rounds toward minus infinity.
      prod = (longint'($signed(operand)) * longint'($signed(scale_q))) >>> FRAC_W;
      sum  = longint'($signed(acc_store[idx])) + prod;
      if (sum > longint'(32'sh7FFF_FFFF)) begin
        sum = longint'(32'sh7FFF_FFFF);
        res.saturated = 1'b1;
      end else if (sum < -longint'(64'sh8000_0000)) begin
        sum = -longint'(64'sh8000_0000);
        res.saturated = 1'b1;
      end
      acc_store[idx] = sum[VAL_W-1:0];
    end
    res.entry_value = acc_store[idx];
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [VAL_W-1:0] random_operand();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return VAL_W'($signed($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000);
    if (roll < 45) return VAL_W'($signed($urandom_range(0, 32'h1FF_FFFF)) - 32'sh100_0000);
    if (roll < 85) return $urandom;
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return 32'h0001_0000;
    endcase
  endfunction

  // Half the indices fall on a few hot entries at either end of the store, so
  // that back-to-back beats often hit the same entry.
  function automatic logic [IDX_W-1:0] random_index();
    case ($urandom_range(0, 3))
      0: return IDX_W'($urandom_range(0, 3));
      1: return IDX_W'(ENTRIES - 1 - $urandom_range(0, 3));
      default: return IDX_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string field, logic [VAL_W-1:0] got,
                                 logic [VAL_W-1:0] want);
    $display("Mismatch in %s at cycle %0d: got %h, expected %h",
             field, cycle_count, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : result_check
    acc_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", out_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.entry_value)
          report_mismatch("entry_value", out_tdata, want.entry_value);
        if (out_tuser !== want.saturated)
          report_mismatch("saturated", VAL_W'(out_tuser), VAL_W'(want.saturated));
        if (out_tlast !== want.batch_done)
          report_mismatch("batch_done", VAL_W'(out_tlast), VAL_W'(want.batch_done));
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        stall_left = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        if (!no_idle && $urandom_range(0, 5) == 0) stall_left = pick_gap();
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_item(logic op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] operand,
                           logic last);
    int gap;
    gap = (no_idle || $urandom_range(0, 9) < 6) ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {{(IN_TDATA_W - VAL_W - IDX_W){1'b0}}, operand, idx};
    in_tuser  = op;
    in_tlast  = last;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(scale_and_accumulate(op, idx, operand, last));
    @(negedge clk);
  endtask

  task automatic send_random_item();
    send_item(($urandom_range(0, 3) == 0) ? OP_READ : OP_UPDATE, random_index(),
              random_operand(), ($urandom_range(0, 7) == 0));
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_scale(logic [VAL_W-1:0] new_scale);
    wait_drained();
    cfg_wdata = new_scale;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    scale_q = new_scale;
  endtask

  // The store must come out of reset cleared, and a read ignores its value.
  task automatic test_cleared_store();
    send_item(OP_READ, '0, 32'hDEAD_BEEF, 1'b0);
    send_item(OP_READ, IDX_W'(ENTRIES - 1), 32'hFFFF_FFFF, 1'b1);
    send_item(OP_READ, IDX_W'(12'hA5A), 32'h0000_0000, 1'b0);
  endtask

  task automatic test_saturation_and_rounding();
    // Unit scale: reach both rails, then push past them.
    send_item(OP_UPDATE, '0, 32'h7FFF_FFFF, 1'b0);
    send_item(OP_UPDATE, '0, 32'h0000_0001, 1'b0);
    send_item(OP_UPDATE, IDX_W'(ENTRIES - 1), 32'h8000_0000, 1'b0);
    send_item(OP_UPDATE, IDX_W'(ENTRIES - 1), 32'hFFFF_FFFF, 1'b1);
    send_item(OP_UPDATE, IDX_W'(5), 32'hFFFF_FFFF, 1'b0);
    send_item(OP_READ, IDX_W'(5), 32'h1234_5678, 1'b1);
    // Smallest scale: a negative fraction must round down, a positive one to zero.
    set_scale(32'h0000_0001);
    send_item(OP_UPDATE, IDX_W'(6), 32'hFFFF_FFFF, 1'b0);
    send_item(OP_UPDATE, IDX_W'(7), 32'h0000_FFFF, 1'b1);
    // Most negative scale: the product of the two minima is far out of range.
    set_scale(32'h8000_0000);
    send_item(OP_UPDATE, IDX_W'(8), 32'h8000_0000, 1'b0);
    send_item(OP_UPDATE, IDX_W'(9), 32'h7FFF_FFFF, 1'b1);
    set_scale(32'h7FFF_FFFF);
    send_item(OP_UPDATE, IDX_W'(10), 32'h7FFF_FFFF, 1'b0);
    send_item(OP_UPDATE, IDX_W'(10), 32'h8000_0000, 1'b0);
    send_item(OP_READ, IDX_W'(10), 32'h0000_0000, 1'b1);
    set_scale(32'h0000_0000);
    send_item(OP_UPDATE, IDX_W'(11), 32'h1234_5678, 1'b0);
    send_item(OP_READ, '0, 32'h0000_0000, 1'b1);
  endtask

  task automatic test_random_scales();
    logic [VAL_W-1:0] scale_set [8];
    scale_set = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h0000_0000, 32'h0000_0001, $urandom, 32'h0000_8000};
    foreach (scale_set[i]) begin
      set_scale(scale_set[i]);
      repeat (PHASE_LEN) send_random_item();
    end
  endtask

  // Full rate in both directions with no idling at all.
  task automatic test_streaming_full_rate();
    set_scale(VAL_W'($urandom_range(32'h0000_4000, 32'h0004_0000)));
    no_idle = 1'b1;
    repeat (150) send_random_item();
    no_idle = 1'b0;
  endtask

  // The receiver holds off while beats keep coming, so the input must stall.
  task automatic test_output_backpressure();
    set_scale(32'hFFFE_0000);
    hold_request = 1'b1;
    no_idle = 1'b1;
    repeat (150) send_random_item();
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_UPDATE;
    in_tlast  = 1'b0;
    scale_q   = 32'h0001_0000;
    foreach (acc_store[i]) acc_store[i] = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_cleared_store();
    test_saturation_and_rounding();
    test_random_scales();
    test_streaming_full_rate();
    test_output_backpressure();

    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
